// File: rtl/core/assert_macros.svh
// Assertion macros shared by the looper RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising edge outside reset.
`define CEL_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Invariant checked at every rising edge outside reset.
`define CEL_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) \
		else $error(msg);

`endif

// File: rtl/core/cel_pkg.sv
// Types, constants and register codes of the control-change looper.
`default_nettype none

package cel_pkg;

	localparam int DEPTH_DEF        = 1024;
	localparam int MAX_PER_TICK_DEF = 16;
	localparam int TIME_BITS_DEF    = 32;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 8;

	// Width of the message fields kept with each stored event.
	localparam int PAYLOAD_W = 19;

	localparam logic [CFG_IDX_W-1:0] CFG_CC_STATUS   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_KEY_STOP    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_KEY_PLAY    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_KEY_RECORD  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_KEY_FORWARD = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_KEY_REWIND  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_LOOP_ENABLE = 3'd6;

	localparam logic [7:0] RST_CC_STATUS   = 8'd176;
	localparam logic [6:0] RST_KEY_STOP    = 7'd42;
	localparam logic [6:0] RST_KEY_PLAY    = 7'd41;
	localparam logic [6:0] RST_KEY_RECORD  = 7'd45;
	localparam logic [6:0] RST_KEY_FORWARD = 7'd44;
	localparam logic [6:0] RST_KEY_REWIND  = 7'd43;
	localparam logic       RST_LOOP_ENABLE = 1'b1;

	localparam logic OP_TICK = 1'b0;
	localparam logic OP_MIDI = 1'b1;

	typedef enum logic [1:0] {
		MODE_IDLE = 2'd0,
		MODE_REC  = 2'd1,
		MODE_PLAY = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'd0,
		ST_SCAN = 2'd1,
		ST_CHK  = 2'd2,
		ST_END  = 2'd3
	} ctrl_state_t;

	typedef struct packed {
		logic tick;       // tick transaction accepted
		logic msg;        // message transaction accepted
		logic rd;         // read the store at the play position
		logic take;       // move the read event into the hold register
		logic push;       // move the hold register into the output register
		logic push_last;  // the pushed event closes this tick
		logic end_chk;    // end-of-store handling
	} ctrl_cmd_t;

	typedef struct packed {
		logic playing;
		logic can_cont;
		logic due;
		logic hold_valid;
		logic out_free;
	} dp_sts_t;

endpackage

`default_nettype wire

// File: rtl/core/cel_if.sv
// Stream interfaces for incoming items and replayed events.
`default_nettype none

interface cel_in_if;
	logic       valid;
	logic       ready;
	logic       op;
	logic [7:0] status;
	logic [4:0] channel;
	logic [6:0] control;
	logic [6:0] value;

	modport source (output valid, output op, output status, output channel,
		output control, output value, input ready);
	modport sink (input valid, input op, input status, input channel,
		input control, input value, output ready);
endinterface

interface cel_out_if;
	logic       valid;
	logic       ready;
	logic [4:0] out_channel;
	logic [6:0] out_control;
	logic [6:0] out_value;
	logic       last;

	modport source (output valid, output out_channel, output out_control,
		output out_value, output last, input ready);
	modport sink (input valid, input out_channel, input out_control,
		input out_value, input last, output ready);
endinterface

`default_nettype wire

// File: rtl/core/cel_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module cel_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/cel_ctrl.sv
// Controller state machine: transaction acceptance and playback scan sequencing.
`default_nettype none
`include "assert_macros.svh"

module cel_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	input  wire logic              in_op,
	output      logic              in_ready,
	input  wire cel_pkg::dp_sts_t  sts,
	output      cel_pkg::ctrl_cmd_t cmd
);

	import cel_pkg::*;

	ctrl_state_t st_q;
	ctrl_state_t st_d;
	logic        hold_blocked;

	// The held event can move on only when the output register has room.
	assign hold_blocked = sts.hold_valid && !sts.out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			ST_IDLE: begin
				if (in_valid && (in_op == OP_TICK) && sts.playing) begin
					st_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				st_d = sts.can_cont ? ST_CHK : ST_END;
			end
			ST_CHK: begin
				if (!sts.due) begin
					st_d = ST_END;
				end else if (!hold_blocked) begin
					st_d = ST_SCAN;
				end
			end
			ST_END: begin
				if (!hold_blocked) begin
					st_d = ST_IDLE;
				end
			end
			default: st_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (st_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.tick = in_valid && (in_op == OP_TICK);
				cmd.msg  = in_valid && (in_op == OP_MIDI);
			end
			ST_SCAN: begin
				cmd.rd = sts.can_cont;
			end
			ST_CHK: begin
				if (sts.due && !hold_blocked) begin
					cmd.take = 1'b1;
					cmd.push = sts.hold_valid;
				end
			end
			ST_END: begin
				if (!hold_blocked) begin
					cmd.push      = sts.hold_valid;
					cmd.push_last = 1'b1;
					cmd.end_chk   = 1'b1;
				end
			end
			default: begin
				cmd      = '0;
				in_ready = 1'b0;
			end
		endcase
	end

	`CEL_ASSERT_IMP(a_idle_no_hold, clk, arst_n, st_q == ST_IDLE, !sts.hold_valid, "held event left behind at end of tick")

endmodule

`default_nettype wire

// File: rtl/core/cel_dp.sv
// Datapath: configuration, transport state, event store and output register.
`default_nettype none
`include "assert_macros.svh"

module cel_dp #(
	parameter int DEPTH        = cel_pkg::DEPTH_DEF,
	parameter int MAX_PER_TICK = cel_pkg::MAX_PER_TICK_DEF,
	parameter int TIME_BITS    = cel_pkg::TIME_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [cel_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [cel_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic [7:0]                    in_status,
	input  wire logic [4:0]                    in_channel,
	input  wire logic [6:0]                    in_control,
	input  wire logic [6:0]                    in_value,
	input  wire cel_pkg::ctrl_cmd_t            cmd,
	output      cel_pkg::dp_sts_t              sts,
	output      logic                          out_valid,
	input  wire logic                          out_ready,
	output      logic [4:0]                    out_channel,
	output      logic [6:0]                    out_control,
	output      logic [6:0]                    out_value,
	output      logic                          out_last
);

	import cel_pkg::*;

	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int N_W   = $clog2(MAX_PER_TICK + 1);
	localparam int ENT_W = TIME_BITS + PAYLOAD_W;

	logic [7:0] cc_status_q;
	logic [6:0] key_stop_q;
	logic [6:0] key_play_q;
	logic [6:0] key_record_q;
	logic [6:0] key_forward_q;
	logic [6:0] key_rewind_q;
	logic       loop_enable_q;

	logic [TIME_BITS-1:0] now_q;
	logic [TIME_BITS-1:0] record_start_q;
	logic [TIME_BITS-1:0] play_start_q;
	logic [TIME_BITS-1:0] elapsed_q;
	mode_t                mode_q;
	logic [CNT_W-1:0]     pos_q;
	logic [CNT_W-1:0]     count_q;
	logic [N_W-1:0]       n_q;

	logic                 hold_valid_q;
	logic [PAYLOAD_W-1:0] hold_q;
	logic                 out_valid_q;
	logic [PAYLOAD_W-1:0] out_q;
	logic                 out_last_q;

	logic                 is_cc;
	logic                 hit_swallow;
	logic                 hit_stop;
	logic                 hit_play;
	logic                 hit_record;
	logic                 rec_we;
	logic [ENT_W-1:0]     rec_wdata;
	logic [ENT_W-1:0]     rd_data;
	logic [TIME_BITS-1:0] rd_time;

	assign is_cc       = cmd.msg && (in_status == cc_status_q);
	assign hit_swallow = (in_control == key_forward_q) || (in_control == key_rewind_q);
	assign hit_stop    = in_control == key_stop_q;
	assign hit_play    = in_control == key_play_q;
	assign hit_record  = in_control == key_record_q;

	// A plain control change is stored only while recording and while room is left.
	assign rec_we = is_cc && !hit_swallow && !hit_stop && !hit_play && !hit_record
		&& (mode_q == MODE_REC) && (count_q < CNT_W'(DEPTH));
	assign rec_wdata = {now_q - record_start_q, in_channel, in_control, in_value};

	cel_ram #(
		.WIDTH(ENT_W),
		.DEPTH(DEPTH)
	) u_store (
		.clk  (clk),
		.we   (rec_we),
		.waddr(count_q[IDX_W-1:0]),
		.wdata(rec_wdata),
		.re   (cmd.rd),
		.raddr(pos_q[IDX_W-1:0]),
		.rdata(rd_data)
	);

	assign rd_time = rd_data[ENT_W-1:PAYLOAD_W];

	assign sts.playing    = mode_q == MODE_PLAY;
	assign sts.can_cont   = (n_q < N_W'(MAX_PER_TICK)) && (pos_q < count_q);
	assign sts.due        = rd_time <= elapsed_q;
	assign sts.hold_valid = hold_valid_q;
	assign sts.out_free   = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cc_status_q   <= RST_CC_STATUS;
			key_stop_q    <= RST_KEY_STOP;
			key_play_q    <= RST_KEY_PLAY;
			key_record_q  <= RST_KEY_RECORD;
			key_forward_q <= RST_KEY_FORWARD;
			key_rewind_q  <= RST_KEY_REWIND;
			loop_enable_q <= RST_LOOP_ENABLE;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_CC_STATUS:   cc_status_q   <= cfg_data;
				CFG_KEY_STOP:    key_stop_q    <= cfg_data[6:0];
				CFG_KEY_PLAY:    key_play_q    <= cfg_data[6:0];
				CFG_KEY_RECORD:  key_record_q  <= cfg_data[6:0];
				CFG_KEY_FORWARD: key_forward_q <= cfg_data[6:0];
				CFG_KEY_REWIND:  key_rewind_q  <= cfg_data[6:0];
				CFG_LOOP_ENABLE: loop_enable_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			now_q          <= '0;
			record_start_q <= '0;
			play_start_q   <= '0;
			mode_q         <= MODE_IDLE;
			pos_q          <= '0;
			count_q        <= '0;
			n_q            <= '0;
			hold_valid_q   <= 1'b0;
			out_valid_q    <= 1'b0;
		end else begin
			if (cmd.tick) begin
				now_q <= now_q + TIME_BITS'(1);
				n_q   <= '0;
			end
			if (is_cc && !hit_swallow) begin
				priority if (hit_stop) begin
					mode_q <= MODE_IDLE;
				end else if (hit_play) begin
					if (mode_q != MODE_PLAY) begin
						mode_q       <= MODE_PLAY;
						pos_q        <= '0;
						play_start_q <= now_q;
					end
				end else if (hit_record) begin
					if (mode_q != MODE_REC) begin
						mode_q         <= MODE_REC;
						record_start_q <= now_q;
					end
				end else begin
					if (rec_we) begin
						count_q <= count_q + CNT_W'(1);
					end
				end
			end
			if (cmd.take) begin
				pos_q <= pos_q + CNT_W'(1);
				n_q   <= n_q + N_W'(1);
			end
			if (cmd.end_chk && (pos_q >= count_q)) begin
				if (loop_enable_q) begin
					pos_q        <= '0;
					play_start_q <= now_q;
				end else begin
					mode_q <= MODE_IDLE;
				end
			end
			if (cmd.take) begin
				hold_valid_q <= 1'b1;
			end else if (cmd.push) begin
				hold_valid_q <= 1'b0;
			end
			if (cmd.push) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			elapsed_q <= now_q - play_start_q;
		end
		if (cmd.take) begin
			hold_q <= rd_data[PAYLOAD_W-1:0];
		end
		if (cmd.push) begin
			out_q      <= hold_q;
			out_last_q <= cmd.push_last;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_channel = out_q[18:14];
	assign out_control = out_q[13:7];
	assign out_value   = out_q[6:0];
	assign out_last    = out_last_q;

	`CEL_ASSERT_IMP(a_push_has_room, clk, arst_n, cmd.push, !out_valid_q || out_ready, "output register overwritten")
	`CEL_ASSERT_IMP(a_take_in_range, clk, arst_n, cmd.take, (pos_q < count_q) && (n_q < N_W'(MAX_PER_TICK)), "event taken past the end or the tick limit")
	`CEL_ASSERT_ALWAYS(a_count_bound, clk, arst_n, count_q <= CNT_W'(DEPTH), "event count beyond store depth")

endmodule

`default_nettype wire

// File: rtl/core/controller_event_looper.sv
// Top level of the control-change recorder and looper.
// A message transaction, and a tick while not playing, is taken in the idle state. A tick
// during playback starts a scan: for each event it replays, the scan state reads the store
// and the check state compares the registered read data against the elapsed time; the scan
// ends at an event not yet due, at the end of the store or after MAX_PER_TICK events, and
// the end state then does end-of-store handling and pushes the last held event;
// a stalled output stretches the scan. The last replayed event of a tick sits in
// the output register while the next transaction is already accepted. Every
// replayed event but the last of its tick has last low. Configuration writes are
// meant for times when no tick is being worked on. The event store powers up
// unknown and needs no clearing pass, as only written entries are ever read.
`default_nettype none

module controller_event_looper #(
	parameter int DEPTH        = cel_pkg::DEPTH_DEF,
	parameter int MAX_PER_TICK = cel_pkg::MAX_PER_TICK_DEF,
	parameter int TIME_BITS    = cel_pkg::TIME_BITS_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [cel_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [cel_pkg::CFG_DATA_W-1:0] cfg_data,
	cel_in_if.sink                              item,
	cel_out_if.source                           result
);

	import cel_pkg::*;

	ctrl_cmd_t cmd;
	dp_sts_t   sts;
	logic      in_ready;

	cel_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(item.valid),
		.in_op   (item.op),
		.in_ready(in_ready),
		.sts     (sts),
		.cmd     (cmd)
	);

	cel_dp #(
		.DEPTH       (DEPTH),
		.MAX_PER_TICK(MAX_PER_TICK),
		.TIME_BITS   (TIME_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_status  (item.status),
		.in_channel (item.channel),
		.in_control (item.control),
		.in_value   (item.value),
		.cmd        (cmd),
		.sts        (sts),
		.out_valid  (result.valid),
		.out_ready  (result.ready),
		.out_channel(result.out_channel),
		.out_control(result.out_control),
		.out_value  (result.out_value),
		.out_last   (result.last)
	);

	assign item.ready = in_ready;

endmodule

`default_nettype wire

// File: verif/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench of the control-change looper with predicted replays.

module testbench;
	import cel_pkg::*;

	localparam int DEPTH        = DEPTH_DEF;
	localparam int MAX_PER_TICK = MAX_PER_TICK_DEF;
	localparam int TIME_BITS    = TIME_BITS_DEF;
	localparam int SETTLE       = 2 * MAX_PER_TICK + 16;
	localparam int STALL_LIMIT  = 4000;
	localparam int HOLD_CYCLES  = 600;
	localparam int BURST        = 2 * MAX_PER_TICK;

	typedef struct packed {
		logic       op;
		logic [7:0] status;
		logic [4:0] channel;
		logic [6:0] control;
		logic [6:0] value;
	} item_t;

	typedef struct packed {
		logic [TIME_BITS-1:0] stamp;
		logic [4:0]           ch;
		logic [6:0]           ctl;
		logic [6:0]           val;
	} stored_cc_t;

	typedef struct packed {
		logic [4:0] ch;
		logic [6:0] ctl;
		logic [6:0] val;
		logic       last;
	} replay_t;

	logic clk;
	logic arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	cel_in_if  item_if ();
	cel_out_if result_if ();

	controller_event_looper #(
		.DEPTH       (DEPTH),
		.MAX_PER_TICK(MAX_PER_TICK),
		.TIME_BITS   (TIME_BITS)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.item     (item_if),
		.result   (result_if)
	);

	// Register copies used by the predictor.
	logic [7:0] cfg_cc;
	logic [6:0] cfg_stop, cfg_play, cfg_rec, cfg_fwd, cfg_rew;
	logic       cfg_loop;

	// Predicted looper state.
	logic [TIME_BITS-1:0] now_cnt, rec_t0, play_t0;
	mode_t                play_mode;
	int                   play_idx, ev_total;
	stored_cc_t           loop_store [DEPTH];

	item_t   item_backlog [$];
	replay_t due_events [$];
	int      items_queued, items_taken;
	int      errors;
	int      send_idle_pct, recv_idle_pct;
	bit      hold_armed;
	int      hold_left;
	bit      hold_used;
	int      stall_cycles;

	always #5 clk = ~clk;

	task automatic advance_looper(input item_t it);
		logic [TIME_BITS-1:0] elapsed;
		replay_t held;
		bit have;
		int n;
		if (it.op == OP_TICK) begin
			now_cnt = now_cnt + TIME_BITS'(1);
			if (play_mode == MODE_PLAY) begin
				elapsed = now_cnt - play_t0;
				n = 0;
				have = 0;
				// Each replay is queued once the next one is known, so the final one gets last.
				while (n < MAX_PER_TICK && play_idx < ev_total &&
					loop_store[play_idx].stamp <= elapsed) begin
					if (have)
						due_events.insert(due_events.size(), held);
					held.ch   = loop_store[play_idx].ch;
					held.ctl  = loop_store[play_idx].ctl;
					held.val  = loop_store[play_idx].val;
					held.last = 1'b0;
					have = 1;
					n++;
					play_idx++;
				end
				if (have) begin
					held.last = 1'b1;
					due_events.insert(due_events.size(), held);
				end
				if (play_idx >= ev_total) begin
					if (cfg_loop) begin
						play_idx = 0;
						play_t0 = now_cnt;
					end else begin
						play_mode = MODE_IDLE;
					end
				end
			end
		end else if (it.status == cfg_cc) begin
			if (it.control == cfg_fwd || it.control == cfg_rew) begin
				// Forward and rewind are taken and do nothing.
			end else if (it.control == cfg_stop) begin
				play_mode = MODE_IDLE;
			end else if (it.control == cfg_play) begin
				if (play_mode != MODE_PLAY) begin
					play_mode = MODE_PLAY;
					play_idx = 0;
					play_t0 = now_cnt;
				end
			end else if (it.control == cfg_rec) begin
				if (play_mode != MODE_REC) begin
					play_mode = MODE_REC;
					rec_t0 = now_cnt;
				end
			end else if (play_mode == MODE_REC && ev_total < DEPTH) begin
				loop_store[ev_total].stamp = now_cnt - rec_t0;
				loop_store[ev_total].ch    = it.channel;
				loop_store[ev_total].ctl   = it.control;
				loop_store[ev_total].val   = it.value;
				ev_total++;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : drive_items
		item_t nxt;
		item_t seen;
		if (!arst_n) begin
			item_if.valid   <= 1'b0;
			item_if.op      <= OP_TICK;
			item_if.status  <= 8'd0;
			item_if.channel <= 5'd0;
			item_if.control <= 7'd0;
			item_if.value   <= 7'd0;
		end else begin
			if (item_if.valid && item_if.ready) begin
				seen.op      = item_if.op;
				seen.status  = item_if.status;
				seen.channel = item_if.channel;
				seen.control = item_if.control;
				seen.value   = item_if.value;
				advance_looper(seen);
				items_taken++;
			end
			if (!item_if.valid || item_if.ready) begin
				if (item_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					nxt = item_backlog.pop_front();
					item_if.valid   <= 1'b1;
					item_if.op      <= nxt.op;
					item_if.status  <= nxt.status;
					item_if.channel <= nxt.channel;
					item_if.control <= nxt.control;
					item_if.value   <= nxt.value;
				end else begin
					item_if.valid <= 1'b0;
				end
			end
		end
	end

	// Output backpressure, including one long hold while playback is busy.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_if.ready <= 1'b0;
			hold_left <= 0;
			hold_used <= 1'b0;
		end else if (hold_left != 0) begin
			result_if.ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_armed && !hold_used && result_if.valid) begin
			result_if.ready <= 1'b0;
			hold_left <= HOLD_CYCLES;
			hold_used <= 1'b1;
		end else begin
			result_if.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin : check_replays
		replay_t got;
		replay_t want;
		if (arst_n && result_if.valid && result_if.ready) begin
			got.ch   = result_if.out_channel;
			got.ctl  = result_if.out_control;
			got.val  = result_if.out_value;
			got.last = result_if.last;
			if (due_events.size() == 0) begin
				$display("%0t: unexpected replay ch %0d ctl %0d val %0d last %0d",
					$time, got.ch, got.ctl, got.val, got.last);
				errors++;
			end else begin
				want = due_events.pop_front();
				if (got.ch !== want.ch || got.ctl !== want.ctl ||
					got.val !== want.val || got.last !== want.last) begin
					$display("%0t: replay mismatch: expected ch %0d ctl %0d val %0d last %0d,",
						$time, want.ch, want.ctl, want.val, want.last,
						" got ch %0d ctl %0d val %0d last %0d",
						got.ch, got.ctl, got.val, got.last);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_if.valid && item_if.ready) || (result_if.valid && result_if.ready))
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	task automatic push_msg(input logic [7:0] st, input logic [4:0] ch, input logic [6:0] ctl,
		input logic [6:0] val);
		item_t it;
		it.op = OP_MIDI;
		it.status = st;
		it.channel = ch;
		it.control = ctl;
		it.value = val;
		item_backlog.insert(item_backlog.size(), it);
		items_queued++;
	endtask

	// Ticks carry random content in the fields that they ignore.
	task automatic push_tick();
		item_t it;
		it.op = OP_TICK;
		it.status = 8'($urandom_range(255));
		it.channel = 5'($urandom_range(16, 1));
		it.control = 7'($urandom_range(127));
		it.value = 7'($urandom_range(127));
		item_backlog.insert(item_backlog.size(), it);
		items_queued++;
	endtask

	task automatic push_cc(input logic [6:0] ctl);
		push_msg(cfg_cc, 5'($urandom_range(16, 1)), ctl, 7'($urandom_range(127)));
	endtask

	function automatic logic [6:0] plain_control();
		logic [6:0] c;
		c = 7'($urandom_range(127));
		while (c == cfg_stop || c == cfg_play || c == cfg_rec || c == cfg_fwd || c == cfg_rew)
			c = 7'($urandom_range(127));
		return c;
	endfunction

	// Play then record always gives a fresh recording start, whatever the mode.
	task automatic record_session();
		int n;
		push_cc(cfg_play);
		push_cc(cfg_rec);
		n = ($urandom_range(9) == 0) ? $urandom_range(40, 17) : $urandom_range(12);
		repeat (n) begin
			if ($urandom_range(3) == 0)
				repeat ($urandom_range(2, 1)) push_tick();
			push_cc(plain_control());
		end
		push_cc(cfg_play);
		repeat ($urandom_range(30, 4)) push_tick();
		if ($urandom_range(2) == 0)
			push_cc(cfg_stop);
	endtask

	task automatic push_noise();
		logic [7:0] st;
		logic [6:0] ctl;
		if ($urandom_range(4) < 2) begin
			push_tick();
		end else begin
			st = $urandom_range(1) ? cfg_cc : 8'($urandom_range(255));
			case ($urandom_range(7))
				0: ctl = cfg_stop;
				1: ctl = cfg_play;
				2: ctl = cfg_rec;
				3: ctl = cfg_fwd;
				4: ctl = cfg_rew;
				default: ctl = 7'($urandom_range(127));
			endcase
			push_msg(st, 5'($urandom_range(16, 1)), ctl, 7'($urandom_range(127)));
		end
	endtask

	task automatic push_random(input int count);
		int start;
		start = items_queued;
		while (items_queued - start < count) begin
			if ($urandom_range(99) < 75)
				record_session();
			else
				repeat ($urandom_range(6, 1)) push_noise();
		end
	endtask

	// Records a burst of events at one time stamp, then plays the whole store back with
	// the long output hold, so that the output side backs up into the input.
	task automatic burst_and_replay();
		logic [TIME_BITS-1:0] latest;
		int i;
		latest = '0;
		for (i = 0; i < ev_total; i++)
			if (loop_store[i].stamp > latest)
				latest = loop_store[i].stamp;
		push_cc(cfg_play);
		push_cc(cfg_rec);
		repeat (BURST) push_cc(plain_control());
		hold_armed = 1'b1;
		push_cc(cfg_play);
		repeat (int'(latest) + (ev_total + BURST) / MAX_PER_TICK + 8) push_tick();
	endtask

	task automatic wait_drain();
		while (items_taken != items_queued)
			@(posedge clk);
		while (due_events.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
	endtask

	task automatic program_looper(input logic [7:0] cc, input logic [6:0] stop, play, rec, fwd,
		rew, input logic loop_on);
		write_reg(CFG_CC_STATUS, cc);
		write_reg(CFG_KEY_STOP, {1'b0, stop});
		write_reg(CFG_KEY_PLAY, {1'b0, play});
		write_reg(CFG_KEY_RECORD, {1'b0, rec});
		write_reg(CFG_KEY_FORWARD, {1'b0, fwd});
		write_reg(CFG_KEY_REWIND, {1'b0, rew});
		write_reg(CFG_LOOP_ENABLE, {7'd0, loop_on});
		cfg_we <= 1'b0;
		cfg_cc = cc;
		cfg_stop = stop;
		cfg_play = play;
		cfg_rec = rec;
		cfg_fwd = fwd;
		cfg_rew = rew;
		cfg_loop = loop_on;
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		item_if.valid = 1'b0;
		item_if.op = OP_TICK;
		item_if.status = 8'd0;
		item_if.channel = 5'd0;
		item_if.control = 7'd0;
		item_if.value = 7'd0;
		result_if.ready = 1'b0;
		cfg_cc = RST_CC_STATUS;
		cfg_stop = RST_KEY_STOP;
		cfg_play = RST_KEY_PLAY;
		cfg_rec = RST_KEY_RECORD;
		cfg_fwd = RST_KEY_FORWARD;
		cfg_rew = RST_KEY_REWIND;
		cfg_loop = RST_LOOP_ENABLE;
		now_cnt = '0;
		rec_t0 = '0;
		play_t0 = '0;
		play_mode = MODE_IDLE;
		play_idx = 0;
		ev_total = 0;
		items_queued = 0;
		items_taken = 0;
		errors = 0;
		hold_armed = 1'b0;
		stall_cycles = 0;
		send_idle_pct = 22;
		recv_idle_pct = 85;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (3) @(posedge clk);

		// Directed traffic under the reset register values.
		push_msg(8'd255, 5'd16, 7'd127, 7'd127);
		item_backlog[0].op = OP_TICK;
		push_msg(8'd177, 5'd1, cfg_rec, 7'd0);
		push_cc(cfg_play);
		push_tick();
		push_cc(cfg_rec);
		push_msg(cfg_cc, 5'd1, 7'd0, 7'd0);
		push_tick();
		push_msg(cfg_cc, 5'd16, 7'd127, 7'd127);
		push_cc(cfg_fwd);
		push_cc(cfg_rew);
		push_cc(cfg_rec);
		push_tick();
		push_tick();
		push_msg(cfg_cc, 5'd7, 7'd5, 7'd64);
		push_msg(8'd0, 5'd2, 7'd9, 7'd1);
		push_msg(8'd255, 5'd3, 7'd10, 7'd2);
		push_cc(cfg_play);
		push_cc(cfg_play);
		repeat (4) push_tick();
		push_cc(cfg_stop);
		push_tick();
		wait_drain();

		// Forward and rewind share a number; playback stops at the end.
		program_looper(8'd255, 7'd0, 7'd127, 7'd1, 7'd2, 7'd2, 1'b0);
		push_random(75);
		wait_drain();

		send_idle_pct = 85;
		recv_idle_pct = 22;
		// Rewind shadows stop; playback loops.
		program_looper(8'd0, 7'd100, 7'd101, 7'd102, 7'd103, 7'd100, 1'b1);
		push_random(75);
		wait_drain();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		program_looper(8'd181, 7'd20, 7'd21, 7'd22, 7'd23, 7'd24, 1'b1);
		push_random(65);
		wait_drain();
		burst_and_replay();
		wait_drain();

		// Stop shadows play and forward shadows record.
		program_looper(8'd176, 7'd40, 7'd40, 7'd41, 7'd41, 7'd42, 1'b0);
		repeat (3) push_tick();
		push_cc(7'd41);
		push_cc(7'd40);
		push_tick();
		push_cc(7'd42);
		push_cc(7'd40);
		push_tick();
		wait_drain();

		// Play shadows record.
		program_looper(8'd0, 7'd50, 7'd51, 7'd51, 7'd52, 7'd53, 1'b1);
		push_cc(7'd51);
		repeat (3) push_tick();
		push_cc(7'd51);
		push_tick();
		push_cc(7'd50);
		push_tick();
		wait_drain();

		if (errors == 0 && due_events.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
